### hw/rtl/reader_writer_display_lock_core_defines.svh
// Assertion macros shared by the lock arbiter RTL.
// Included by files that carry concurrent assertions; needs no package.
`ifndef READER_WRITER_DISPLAY_LOCK_CORE_DEFINES_SVH
`define READER_WRITER_DISPLAY_LOCK_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RWDL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RWDL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rwdl_pkg.sv
// Package for the reader/writer/display lock arbiter.
// Holds sizes, action, role and status codes; used by every RTL file but rwdl_ram.
`default_nettype none

package rwdl_pkg;

  localparam int REQUESTERS = 16;
  localparam int HOLD_LIMIT = 255;

  localparam int ACTION_W = 3;
  localparam int REQ_W    = 4;
  localparam int STATUS_W = 2;

  localparam int ADDR_W  = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int HOLD_W  = $clog2(HOLD_LIMIT + 1);
  localparam int TOTAL_W = $clog2(REQUESTERS * HOLD_LIMIT + 1);
  // One memory word holds the write, read and display counts of one requester.
  localparam int WORD_W  = 3 * HOLD_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START_WRITE   = 3'd0,
    ACT_END_WRITE     = 3'd1,
    ACT_START_READ    = 3'd2,
    ACT_END_READ      = 3'd3,
    ACT_START_DISPLAY = 3'd4,
    ACT_END_DISPLAY   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ROLE_WRITE   = 2'd0,
    ROLE_READ    = 2'd1,
    ROLE_DISPLAY = 2'd2
  } role_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_WAIT   = 2'd1,
    ST_NOHOLD = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/rwdl_in_if.sv
// Request channel of the lock arbiter: valid/ready plus action and requester.
// Depends on rwdl_pkg for field widths.
`default_nettype none

interface rwdl_in_if import rwdl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ACTION_W-1:0] action;
  logic [REQ_W-1:0]    requester;

  modport source (output valid, output action, output requester, input ready);
  modport sink   (input valid, input action, input requester, output ready);
endinterface

`default_nettype wire

### hw/rtl/rwdl_out_if.sv
// Result channel of the lock arbiter: valid/ready plus status.
// Depends on rwdl_pkg for field widths.
`default_nettype none

interface rwdl_out_if import rwdl_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/rwdl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module rwdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/reader_writer_display_lock_core.sv
// Reentrant reader/writer/display lock arbiter, top level.
// Uses rwdl_pkg, rwdl_in_if, rwdl_out_if, rwdl_ram and the assertion macros.
//
// Usage:
//   in_ch carries one request transaction: an action (start or end of write,
//   read or display) and a requester id. out_ch returns one status per
//   request: granted/released, wait and retry, end without hold, count full.
//   A refused start changes nothing; the requester simply asks again.
//   cfg_write_en/cfg_write_data write lock_enable (reset 1). With it at 0
//   every start below its count limit is granted; holds are still counted.
// Timing:
//   A request is read from the hold memory in the cycle it is accepted, then
//   checked and written back in the next cycle, which also loads the result
//   register and raises out_ch.valid. One request is in flight at a time, so
//   a new request is taken only once the previous one has been written back;
//   the memory read-modify-write sets that limit.
// Reset and stall:
//   Reset clears all hold counts (per-entry valid bits make untouched entries
//   read as zero), the role totals and the result valid flag. While out_ch is
//   stalled the result holds, and one more request may be accepted only once
//   the result register is being emptied.
`default_nettype none
`include "reader_writer_display_lock_core_defines.svh"

module reader_writer_display_lock_core import rwdl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_write_en,
  input  wire logic  cfg_write_data,
  rwdl_in_if.sink    in_ch,
  rwdl_out_if.source out_ch
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t               state;
  logic                 lock_enable;
  logic [ACTION_W-1:0]  action;
  logic [ADDR_W-1:0]    addr;
  logic                 in_range;
  logic                 entry_hit;
  logic [REQUESTERS-1:0] entry_valid;
  logic [TOTAL_W-1:0]   write_total;
  logic [TOTAL_W-1:0]   read_total;
  logic [TOTAL_W-1:0]   display_total;
  logic                 out_valid;
  status_t              status;

  logic                 in_accept;
  logic                 mem_we;
  logic [WORD_W-1:0]    mem_rdata;
  logic [WORD_W-1:0]    word;
  logic [WORD_W-1:0]    word_next;
  logic [HOLD_W-1:0]    own_w;
  logic [HOLD_W-1:0]    own_r;
  logic [HOLD_W-1:0]    own_d;
  logic [HOLD_W-1:0]    own;
  logic [HOLD_W-1:0]    own_next;
  logic [TOTAL_W-1:0]   total_next;
  logic                 w_ok;
  logic                 r_ok;
  logic                 d_ok;
  logic                 allowed;
  logic                 is_end;
  logic                 unused_code;
  logic                 change;
  role_t                role;
  status_t              status_next;

  assign in_accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == S_IDLE) && (!out_valid || out_ch.ready);
  assign out_ch.valid = out_valid;
  assign out_ch.status = status;

  rwdl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (REQUESTERS)
  ) u_holds (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr),
    .wdata (word_next),
    .re    (in_accept),
    .raddr (ADDR_W'(in_ch.requester)),
    .rdata (mem_rdata)
  );

  // An entry never written since reset reads as all-zero counts.
  assign word  = entry_hit ? mem_rdata : '0;
  assign own_w = word[HOLD_W-1:0];
  assign own_r = word[2*HOLD_W-1:HOLD_W];
  assign own_d = word[3*HOLD_W-1:2*HOLD_W];

  assign w_ok = (write_total == TOTAL_W'(own_w));
  assign r_ok = (read_total == TOTAL_W'(own_r));
  assign d_ok = (display_total == TOTAL_W'(own_d));

  assign is_end      = action[0];
  assign unused_code = (action > ACT_END_DISPLAY);
  assign role        = role_t'(action[2:1]);

  always_comb begin
    own        = own_w;
    total_next = write_total;
    allowed    = 1'b0;
    word_next  = word;
    unique case (role)
      ROLE_WRITE: begin
        own        = own_w;
        total_next = write_total;
        allowed    = w_ok && r_ok && d_ok;
      end
      ROLE_READ: begin
        own        = own_r;
        total_next = read_total;
        allowed    = w_ok;
      end
      ROLE_DISPLAY: begin
        own        = own_d;
        total_next = display_total;
        allowed    = w_ok && d_ok;
      end
      default: begin
        own        = own_w;
        total_next = write_total;
        allowed    = 1'b0;
      end
    endcase
    allowed = allowed || !lock_enable;

    status_next = ST_OK;
    change      = 1'b0;
    own_next    = own;
    if (unused_code) begin
      status_next = ST_OK;
    end else if (is_end) begin
      if (!in_range || (own == '0)) begin
        status_next = ST_NOHOLD;
      end else begin
        change     = 1'b1;
        own_next   = own - HOLD_W'(1);
        total_next = total_next - TOTAL_W'(1);
      end
    end else begin
      if (!in_range) begin
        status_next = ST_FULL;
      end else if (!allowed) begin
        status_next = ST_WAIT;
      end else if (own >= HOLD_W'(HOLD_LIMIT)) begin
        status_next = ST_FULL;
      end else begin
        change     = 1'b1;
        own_next   = own + HOLD_W'(1);
        total_next = total_next + TOTAL_W'(1);
      end
    end

    unique case (role)
      ROLE_READ:    word_next[2*HOLD_W-1:HOLD_W]   = own_next;
      ROLE_DISPLAY: word_next[3*HOLD_W-1:2*HOLD_W] = own_next;
      default:      word_next[HOLD_W-1:0]          = own_next;
    endcase
  end

  assign mem_we = (state == S_EXEC) && change;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      lock_enable   <= 1'b1;
      entry_valid   <= '0;
      write_total   <= '0;
      read_total    <= '0;
      display_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        lock_enable <= cfg_write_data;
      end
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
          if (change) begin
            entry_valid[addr] <= 1'b1;
            unique case (role)
              ROLE_READ:    read_total    <= total_next;
              ROLE_DISPLAY: display_total <= total_next;
              default:      write_total   <= total_next;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request and result payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      action    <= in_ch.action;
      addr      <= ADDR_W'(in_ch.requester);
      in_range  <= (32'(in_ch.requester) < REQUESTERS);
      entry_hit <= entry_valid[ADDR_W'(in_ch.requester)];
    end
    if (state == S_EXEC) begin
      status <= status_next;
    end
  end

  `RWDL_ASSERT_NEXT(a_accept_exec, clk, rst, in_accept, state == S_EXEC, "accepted request did not start execution")
  `RWDL_ASSERT_NEXT(a_exec_result, clk, rst, state == S_EXEC, out_valid, "executed request produced no result")
  `RWDL_ASSERT_SAME(a_write_total, clk, rst, state == S_EXEC, write_total >= TOTAL_W'(own_w), "write total below a requester count")
  `RWDL_ASSERT_SAME(a_display_total, clk, rst, state == S_EXEC, display_total >= TOTAL_W'(own_d), "display total below a requester count")

endmodule

`default_nettype wire

### test/rwdl_status_checker.sv
`timescale 1ns / 1ps
// Status checker for the lock arbiter: snoops the request, result and config ports,
// predicts each status from its own copy of the hold counts and compares in order.
// Depends on rwdl_pkg, rwdl_in_if and rwdl_out_if.

module rwdl_status_checker import rwdl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write_en,
  input  wire logic cfg_write_data,
  rwdl_in_if        req_ch,
  rwdl_out_if       rsp_ch,
  output int        mismatch_count,
  output int        statuses_due
);

  localparam int REPORT_LIMIT = 10;

  logic               enforce;
  logic [HOLD_W-1:0]  holds [3][REQUESTERS];
  logic [TOTAL_W-1:0] totals [3];
  status_t            due_status [$];
  status_t            want;

  // Applies one request to the predicted lock state and returns its status.
  function automatic status_t arbitrate(action_t act, logic [REQ_W-1:0] id);
    role_t role;
    logic  w_free, r_free, d_free, allowed;
    // Codes past the last defined action are ignored and report success.
    if (act > ACT_END_DISPLAY) return ST_OK;
    role   = role_t'(act[2:1]);
    w_free = totals[ROLE_WRITE] == TOTAL_W'(holds[ROLE_WRITE][id]);
    r_free = totals[ROLE_READ] == TOTAL_W'(holds[ROLE_READ][id]);
    d_free = totals[ROLE_DISPLAY] == TOTAL_W'(holds[ROLE_DISPLAY][id]);
    // The low bit of the action separates an end from a start.
    if (act[0]) begin
      if (holds[role][id] == '0) return ST_NOHOLD;
      holds[role][id]--;
      totals[role]--;
      return ST_OK;
    end
    case (role)
      ROLE_WRITE: begin
        allowed = w_free && r_free && d_free;
      end
      ROLE_READ: begin
        allowed = w_free;
      end
      default: begin
        allowed = w_free && d_free;
      end
    endcase
    if (enforce && !allowed) return ST_WAIT;
    if (holds[role][id] >= HOLD_LIMIT) return ST_FULL;
    holds[role][id]++;
    totals[role]++;
    return ST_OK;
  endfunction

  task automatic flag(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      enforce = 1'b1;
      for (int r = 0; r < 3; r++) begin
        totals[r] = '0;
        for (int i = 0; i < REQUESTERS; i++) holds[r][i] = '0;
      end
      due_status.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_write_en) enforce = cfg_write_data;
      // A result at this edge always belongs to an older request, so pop first.
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_status.size() == 0) begin
          flag($sformatf("status %0d with no request waiting", rsp_ch.status));
        end else begin
          want = due_status.pop_front();
          if (rsp_ch.status !== want)
            flag($sformatf("status expected %s (%0d), got %0d",
                           want.name(), want, rsp_ch.status));
        end
      end
      if (req_ch.valid && req_ch.ready)
        due_status = {due_status,
                      arbitrate(action_t'(req_ch.action), req_ch.requester)};
    end
    statuses_due = due_status.size();
  end

endmodule

### test/reader_writer_display_lock_core_test.sv
`timescale 1ns / 1ps
// Top of the lock arbiter testbench: clock, reset, request stimulus, result back-pressure,
// lock_enable writes and the verdict. Uses rwdl_pkg, the channel interfaces and the checker.

module reader_writer_display_lock_core_test import rwdl_pkg::*;;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_OFF      = 64;
  localparam logic [REQ_W-1:0] FIRST_ID = '0;
  localparam logic [REQ_W-1:0] LAST_ID  = '1;

  typedef struct {
    logic [REQ_W-1:0] id;
    role_t            role;
  } open_hold_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic cfg_write_data;
  int   tx_idle_pct  = 21;
  int   rx_idle_pct  = 55;
  int   rx_hold_left = 0;
  int   mismatch_count;
  int   statuses_due;
  open_hold_t open_holds [$];
  logic [REQ_W-1:0] fill_id;
  role_t            fill_role;

  rwdl_in_if  req_ch ();
  rwdl_out_if rsp_ch ();

  reader_writer_display_lock_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_ch          (req_ch),
    .out_ch         (rsp_ch)
  );

  rwdl_status_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req_ch         (req_ch),
    .rsp_ch         (rsp_ch),
    .mismatch_count (mismatch_count),
    .statuses_due   (statuses_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin : receiver
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rsp_ch.ready = 1'b0;
        rx_hold_left--;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_request(action_t act, logic [REQ_W-1:0] id);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.action    = act;
    req_ch.requester = id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_all_statuses();
    req_ch.valid = 1'b0;
    while (statuses_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_lock_enable(logic value);
    cfg_write_data = value;
    cfg_write_en   = 1'b1;
    @(negedge clk);
    cfg_write_en   = 1'b0;
  endtask

  // Mostly start/end pairs of a few busy requesters, ended in random order,
  // so holds overlap and nest; the rest is arbitrary requests.
  task automatic run_sessions(int count);
    open_hold_t h;
    int pick, k;
    repeat (count) begin
      pick = $urandom_range(99);
      if (open_holds.size() > 0 && (pick < 40 || open_holds.size() >= 12)) begin
        k = $urandom_range(open_holds.size() - 1);
        h = open_holds[k];
        open_holds.delete(k);
        send_request(action_t'({h.role, 1'b1}), h.id);
      end else if (pick < 85) begin
        h.id   = ($urandom_range(99) < 70) ? REQ_W'($urandom_range(3)) : REQ_W'($urandom);
        h.role = role_t'($urandom_range(2));
        open_holds = {open_holds, h};
        send_request(action_t'({h.role, 1'b0}), h.id);
      end else begin
        send_request(action_t'($urandom_range(ACT_END_DISPLAY)), REQ_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    rst              = 1'b1;
    cfg_write_en     = 1'b0;
    cfg_write_data   = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_START_WRITE;
    req_ch.requester = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    write_lock_enable(1'b1);

    // Reentrant writer, then readers and displayers against each other.
    repeat (2) send_request(ACT_START_WRITE, FIRST_ID);
    send_request(ACT_START_READ, LAST_ID);
    send_request(ACT_START_DISPLAY, LAST_ID);
    send_request(ACT_START_WRITE, LAST_ID);
    send_request(ACT_START_READ, FIRST_ID);
    send_request(ACT_START_DISPLAY, FIRST_ID);
    repeat (3) send_request(ACT_END_WRITE, FIRST_ID);
    send_request(ACT_START_READ, LAST_ID);
    send_request(ACT_START_DISPLAY, LAST_ID);
    send_request(ACT_START_WRITE, LAST_ID);
    send_request(ACT_END_DISPLAY, FIRST_ID);
    send_request(ACT_START_DISPLAY, LAST_ID);
    send_request(ACT_START_WRITE, FIRST_ID);
    send_request(ACT_END_DISPLAY, LAST_ID);
    send_request(ACT_END_READ, FIRST_ID);
    repeat (2) send_request(ACT_END_READ, LAST_ID);
    send_request(ACT_END_DISPLAY, REQ_W'(5));
    run_sessions(450);
    wait_all_statuses();

    // Exclusion off; one count is driven past its limit and back below zero.
    tx_idle_pct = 55;
    rx_idle_pct = 21;
    write_lock_enable(1'b0);
    fill_id   = REQ_W'($urandom);
    fill_role = role_t'($urandom_range(2));
    repeat (HOLD_LIMIT + 2) send_request(action_t'({fill_role, 1'b0}), fill_id);
    repeat (HOLD_LIMIT + 1) send_request(action_t'({fill_role, 1'b1}), fill_id);
    run_sessions(300);
    wait_all_statuses();

    // No idling; the result side holds off long enough to stall the requests.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_lock_enable(1'b1);
    rx_hold_left = HOLD_OFF;
    run_sessions(400);
    wait_all_statuses();
    run_sessions(250);
    wait_all_statuses();

    if (mismatch_count == 0 && statuses_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
